### rtl/psn_pkg.sv
// Shared types, constants and step functions of the pen sample normalizer.
package psn_pkg;

	localparam int UNIT_FRAC_BITS  = 14;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int ONE             = 1 << UNIT_FRAC_BITS;

	localparam logic [31:0] DEFAULT_SEED = 32'h9e3779b9;

	// radians to turns, 2^40 / (2 pi), and its two halves for the split product
	localparam logic [37:0] INV_TWO_PI_Q40 = 38'h28BE60DB94;
	localparam logic [18:0] INV_LO         = INV_TWO_PI_Q40[18:0];
	localparam logic [18:0] INV_HI         = INV_TWO_PI_Q40[37:19];
	localparam int          RAD_SHIFT      = 40 + ANGLE_FRAC_BITS - UNIT_FRAC_BITS;
	localparam int          TURN_W         = 40 + ANGLE_FRAC_BITS;

	// speed: floor((2048 v + 125) / 250) through ceil(2^30 / 250)
	localparam logic [22:0] SPD_RECIP = 23'd4294968;
	localparam int          VEL_FULL  = 2000;

	// square root lanes
	localparam int SQ_UP    = 60 - 2 * UNIT_FRAC_BITS;
	localparam int SQ_W     = 62;
	localparam int SQ_STEPS = 31;

	// CORDIC lanes
	localparam int CORD_STEPS = 28;
	localparam int CW         = 34;
	localparam int AW         = 35;
	localparam int AZ_SC      = 30 - UNIT_FRAC_BITS;

	// results that are final after the front stages
	typedef struct packed {
		logic [14:0]        pressure;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic [14:0]        speed;
		logic [13:0]        heading;
		logic [13:0]        rotation;
		logic [31:0]        seed;
		logic [14:0]        srand;
	} side_t;

	// two floor square roots in flight
	typedef struct packed {
		logic [SQ_W-1:0] va;
		logic [SQ_W-1:0] ra;
		logic [SQ_W-1:0] vb;
		logic [SQ_W-1:0] rb;
	} sq_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] a;
	} lane_t;

	typedef struct packed {
		lane_t el;
		lane_t az;
		logic  az_zero;
	} cord_t;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic signed [AW-1:0] atan_turns(input logic [4:0] idx);
		logic signed [AW-1:0] r;
		case (idx)
			5'd0:  r = 35'sh020000000;
			5'd1:  r = 35'sh012E4051E;
			5'd2:  r = 35'sh009FB385B;
			5'd3:  r = 35'sh0051111D4;
			5'd4:  r = 35'sh0028B0D43;
			5'd5:  r = 35'sh00145D7E1;
			5'd6:  r = 35'sh000A2F61E;
			5'd7:  r = 35'sh000517C55;
			5'd8:  r = 35'sh00028BE53;
			5'd9:  r = 35'sh000145F2F;
			5'd10: r = 35'sh0000A2F98;
			5'd11: r = 35'sh0000517CC;
			5'd12: r = 35'sh000028BE6;
			5'd13: r = 35'sh0000145F3;
			5'd14: r = 35'sh00000A2F9;
			5'd15: r = 35'sh00000517C;
			5'd16: r = 35'sh0000028BE;
			5'd17: r = 35'sh00000145F;
			5'd18: r = 35'sh000000A2F;
			5'd19: r = 35'sh000000517;
			5'd20: r = 35'sh00000028B;
			5'd21: r = 35'sh000000145;
			5'd22: r = 35'sh0000000A2;
			5'd23: r = 35'sh000000051;
			5'd24: r = 35'sh000000028;
			5'd25: r = 35'sh000000014;
			5'd26: r = 35'sh00000000A;
			5'd27: r = 35'sh000000005;
			default: r = '0;
		endcase
		return r;
	endfunction

	// one vectoring rotation toward the x axis
	function automatic lane_t cordic_step(input lane_t l, input logic [4:0] idx);
		lane_t                r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = l.x >>> idx;
		ys = l.y >>> idx;
		if (l.y > 0) begin
			r.x = l.x + ys;
			r.y = l.y - xs;
			r.a = l.a + atan_turns(idx);
		end else begin
			r.x = l.x - ys;
			r.y = l.y + xs;
			r.a = l.a - atan_turns(idx);
		end
		return r;
	endfunction

endpackage

### rtl/psn_front.sv
// Front stages: clamps, speed and angle products, squares for the roots.
module psn_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [15:0]  pen_pressure,
	input  logic signed [15:0]  tilt_horizontal,
	input  logic signed [15:0]  tilt_vertical,
	input  logic [15:0]         pen_velocity,
	input  logic signed [14:0]  stroke_heading,
	input  logic signed [15:0]  barrel_rotation,
	input  logic [31:0]         seed_in,
	input  logic signed [15:0]  stroke_rand_in,
	output logic                valid_o,
	output psn_pkg::sq_t        sq_o,
	output psn_pkg::side_t      side_o
);

	localparam logic signed [15:0] ONE_S  = 16'(psn_pkg::ONE);
	localparam logic signed [15:0] MONE_S = -16'(psn_pkg::ONE);
	localparam int TURN_W_L = psn_pkg::TURN_W;

	logic               valid_s1;
	logic [14:0]        pressure_s1;
	logic signed [15:0] tx_s1;
	logic signed [15:0] ty_s1;
	logic [14:0]        big_s1;
	logic [14:0]        small_s1;
	logic               vel_big_s1;
	logic [44:0]        spd_prod_s1;
	logic signed [36:0] hd_lo_s1;
	logic signed [36:0] hd_hi_s1;
	logic signed [36:0] rot_lo_s1;
	logic signed [36:0] rot_hi_s1;
	logic [31:0]        seed_s1;
	logic [14:0]        srand_s1;

	logic               valid_s2;
	psn_pkg::sq_t       sq_s2;
	psn_pkg::side_t     side_s2;

	logic signed [15:0] tx_c;
	logic signed [15:0] ty_c;
	logic [14:0]        ax_c;
	logic [14:0]        ay_c;
	logic [21:0]        spd_n_c;
	logic signed [16:0] hd_c;
	logic signed [16:0] rot_c;
	logic [29:0]        big_sq_c;
	logic [29:0]        small_sq_c;
	logic [29:0]        sa_c;
	logic [29:0]        sb_c;
	logic [TURN_W_L-1:0] hd_tot_c;
	logic [TURN_W_L-1:0] rot_tot_c;

	// clamp to 0..1 for the unsigned unit fields
	function automatic logic [14:0] clamp_unit(input logic signed [15:0] v);
		logic [14:0] r;
		if (v < 0)
			r = '0;
		else if (v > ONE_S)
			r = 15'(psn_pkg::ONE);
		else
			r = v[14:0];
		return r;
	endfunction

	// stage 1 operands
	always_comb begin
		tx_c = tilt_horizontal < MONE_S ? MONE_S :
			(tilt_horizontal > ONE_S ? ONE_S : tilt_horizontal);
		ty_c = tilt_vertical < MONE_S ? MONE_S :
			(tilt_vertical > ONE_S ? ONE_S : tilt_vertical);
		ax_c = tx_c < 0 ? 15'(-tx_c) : tx_c[14:0];
		ay_c = ty_c < 0 ? 15'(-ty_c) : ty_c[14:0];
		spd_n_c = {pen_velocity[10:0], 11'b0} + 22'd125;
		hd_c = 17'(stroke_heading);
		rot_c = 17'(barrel_rotation);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pressure_s1 <= clamp_unit(pen_pressure);
			tx_s1 <= tx_c;
			ty_s1 <= ty_c;
			big_s1 <= ax_c > ay_c ? ax_c : ay_c;
			small_s1 <= ax_c > ay_c ? ay_c : ax_c;
			vel_big_s1 <= pen_velocity >= 16'(psn_pkg::VEL_FULL);
			spd_prod_s1 <= spd_n_c * psn_pkg::SPD_RECIP;
			hd_lo_s1 <= hd_c * $signed({1'b0, psn_pkg::INV_LO});
			hd_hi_s1 <= hd_c * $signed({1'b0, psn_pkg::INV_HI});
			rot_lo_s1 <= rot_c * $signed({1'b0, psn_pkg::INV_LO});
			rot_hi_s1 <= rot_c * $signed({1'b0, psn_pkg::INV_HI});
			seed_s1 <= seed_in == '0 ? psn_pkg::DEFAULT_SEED : seed_in;
			srand_s1 <= clamp_unit(stroke_rand_in);
		end
	end

	// stage 2 operands: squares and the turn sums
	always_comb begin
		big_sq_c = big_s1 * big_s1;
		small_sq_c = small_s1 * small_s1;
		sa_c = 30'(psn_pkg::ONE * psn_pkg::ONE) - big_sq_c;
		sb_c = big_sq_c + small_sq_c;
		hd_tot_c = {hd_hi_s1[TURN_W_L-20:0], 19'b0} + TURN_W_L'(hd_lo_s1)
			+ (TURN_W_L'(1) << (TURN_W_L - 1));
		rot_tot_c = {rot_hi_s1[TURN_W_L-20:0], 19'b0} + TURN_W_L'(rot_lo_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2.va <= psn_pkg::SQ_W'(sa_c) << psn_pkg::SQ_UP;
			sq_s2.vb <= psn_pkg::SQ_W'(sb_c) << psn_pkg::SQ_UP;
			sq_s2.ra <= '0;
			sq_s2.rb <= '0;
			side_s2.pressure <= pressure_s1;
			side_s2.tx <= tx_s1;
			side_s2.ty <= ty_s1;
			side_s2.speed <= vel_big_s1 ? 15'(psn_pkg::ONE) : spd_prod_s1[44:30];
			side_s2.heading <= hd_tot_c[TURN_W_L-1:psn_pkg::RAD_SHIFT];
			side_s2.rotation <= rot_tot_c[TURN_W_L-1:psn_pkg::RAD_SHIFT];
			side_s2.seed <= seed_s1;
			side_s2.srand <= srand_s1;
		end
	end

	assign valid_o = valid_s2;
	assign sq_o    = sq_s2;
	assign side_o  = side_s2;

endmodule

### rtl/psn_sqrt_cell.sv
// One digit step of two floor square roots, with the finished fields riding along.
module psn_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [4:0]     idx,
	input  logic           valid_i,
	input  psn_pkg::sq_t   sq_i,
	input  psn_pkg::side_t side_i,
	output logic           valid_o,
	output psn_pkg::sq_t   sq_o,
	output psn_pkg::side_t side_o
);

	logic           valid_q;
	psn_pkg::sq_t   sq_q;
	psn_pkg::side_t side_q;
	psn_pkg::sq_t   sq_n;
	logic [psn_pkg::SQ_W-1:0] bit_v;
	logic [psn_pkg::SQ_W-1:0] sum_a;
	logic [psn_pkg::SQ_W-1:0] sum_b;

	// try the digit at 4^idx on both lanes
	always_comb begin
		bit_v = psn_pkg::SQ_W'(1) << {idx, 1'b0};
		sum_a = sq_i.ra + bit_v;
		sum_b = sq_i.rb + bit_v;
		if (sq_i.va >= sum_a) begin
			sq_n.va = sq_i.va - sum_a;
			sq_n.ra = (sq_i.ra >> 1) + bit_v;
		end else begin
			sq_n.va = sq_i.va;
			sq_n.ra = sq_i.ra >> 1;
		end
		if (sq_i.vb >= sum_b) begin
			sq_n.vb = sq_i.vb - sum_b;
			sq_n.rb = (sq_i.rb >> 1) + bit_v;
		end else begin
			sq_n.vb = sq_i.vb;
			sq_n.rb = sq_i.rb >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= sq_n;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign sq_o    = sq_q;
	assign side_o  = side_q;

endmodule

### rtl/psn_cordic_cell.sv
// One CORDIC vectoring step on the elevation and azimuth lanes.
module psn_cordic_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [4:0]     idx,
	input  logic           valid_i,
	input  psn_pkg::cord_t cord_i,
	input  psn_pkg::side_t side_i,
	output logic           valid_o,
	output psn_pkg::cord_t cord_o,
	output psn_pkg::side_t side_o
);

	logic           valid_q;
	psn_pkg::cord_t cord_q;
	psn_pkg::side_t side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// rotate both lanes and hand on
	always_ff @(posedge clk) begin
		if (en) begin
			cord_q.el <= psn_pkg::cordic_step(cord_i.el, idx);
			cord_q.az <= psn_pkg::cordic_step(cord_i.az, idx);
			cord_q.az_zero <= cord_i.az_zero;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign cord_o  = cord_q;
	assign side_o  = side_q;

endmodule

### rtl/pen_sample_context_normalizer.sv
// Top level of the pen sample normalizer: front stages, root cells, CORDIC cells, output register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | pen_pressure .. stroke_rand_in (8 fields)
//  output   | out_valid / out_stall| pressure_norm .. stroke_rand_norm (10)
//
// One transaction per cycle while the chain is not held; 2 front stages, 31 square
// root cells (one digit each), 28 CORDIC cells (one rotation each), 1 output
// register. The whole chain advances together; it holds while a result waits
// under out_stall, and in_stall follows that hold in the same cycle.
// Reset clears the valid bits only; the data registers are not reset.
module pen_sample_context_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pen_pressure,
	input  logic signed [15:0] tilt_horizontal,
	input  logic signed [15:0] tilt_vertical,
	input  logic [15:0]        pen_velocity,
	input  logic signed [14:0] stroke_heading,
	input  logic signed [15:0] barrel_rotation,
	input  logic [31:0]        seed_in,
	input  logic signed [15:0] stroke_rand_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        pressure_norm,
	output logic signed [15:0] tilt_x_norm,
	output logic signed [15:0] tilt_y_norm,
	output logic [14:0]        elevation,
	output logic [14:0]        azimuth,
	output logic [14:0]        speed_norm,
	output logic [13:0]        heading_fraction,
	output logic [13:0]        rotation_fraction,
	output logic [31:0]        rng_seed_out,
	output logic [14:0]        stroke_rand_norm
);

	localparam int SQN = psn_pkg::SQ_STEPS;
	localparam int CRN = psn_pkg::CORD_STEPS;
	localparam int CW  = psn_pkg::CW;
	localparam int AW  = psn_pkg::AW;
	localparam int U   = psn_pkg::UNIT_FRAC_BITS;

	logic           en;
	logic           sq_v    [0:SQN];
	psn_pkg::sq_t   sq_d    [0:SQN];
	psn_pkg::side_t sq_side [0:SQN];
	logic           cr_v    [0:CRN];
	psn_pkg::cord_t cr_d    [0:CRN];
	psn_pkg::side_t cr_side [0:CRN];

	logic signed [CW-1:0] az_x0;
	logic signed [CW-1:0] az_y0;
	logic signed [AW-1:0] el_a;
	logic signed [AW:0]   az_t;
	logic [14:0]          el_c;
	logic [14:0]          az_c;
	logic [AW-1:0]        el_r;
	logic [AW:0]          az_r;

	logic           out_valid_q;
	psn_pkg::side_t side_q;
	logic [14:0]    elevation_q;
	logic [14:0]    azimuth_q;

	// advance unless a finished result is held
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	psn_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.pen_pressure    (pen_pressure),
		.tilt_horizontal (tilt_horizontal),
		.tilt_vertical   (tilt_vertical),
		.pen_velocity    (pen_velocity),
		.stroke_heading  (stroke_heading),
		.barrel_rotation (barrel_rotation),
		.seed_in         (seed_in),
		.stroke_rand_in  (stroke_rand_in),
		.valid_o         (sq_v[0]),
		.sq_o            (sq_d[0]),
		.side_o          (sq_side[0])
	);

	// square root cells, most significant digit first
	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		psn_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.idx     (5'(SQN - 1 - j)),
			.valid_i (sq_v[j]),
			.sq_i    (sq_d[j]),
			.side_i  (sq_side[j]),
			.valid_o (sq_v[j+1]),
			.sq_o    (sq_d[j+1]),
			.side_o  (sq_side[j+1])
		);
	end

	// CORDIC start: roots for elevation, pre-rotated tilts for azimuth
	always_comb begin
		az_y0 = -(CW'(sq_side[SQN].tx) <<< psn_pkg::AZ_SC);
		az_x0 = CW'(sq_side[SQN].ty) <<< psn_pkg::AZ_SC;
		cr_d[0].el.x = CW'(sq_d[SQN].rb);
		cr_d[0].el.y = CW'(sq_d[SQN].ra);
		cr_d[0].el.a = '0;
		if (az_x0 < 0) begin
			if (az_y0 > 0) begin
				cr_d[0].az.x = az_y0;
				cr_d[0].az.y = -az_x0;
				cr_d[0].az.a = AW'(1) <<< 30;
			end else begin
				cr_d[0].az.x = -az_y0;
				cr_d[0].az.y = az_x0;
				cr_d[0].az.a = -(AW'(1) <<< 30);
			end
		end else begin
			cr_d[0].az.x = az_x0;
			cr_d[0].az.y = az_y0;
			cr_d[0].az.a = '0;
		end
		cr_d[0].az_zero = (sq_side[SQN].tx == 0) && (sq_side[SQN].ty == 0);
	end

	assign cr_v[0]    = sq_v[SQN];
	assign cr_side[0] = sq_side[SQN];

	for (genvar j = 0; j < CRN; j++) begin : g_cordic
		psn_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.idx     (5'(j)),
			.valid_i (cr_v[j]),
			.cord_i  (cr_d[j]),
			.side_i  (cr_side[j]),
			.valid_o (cr_v[j+1]),
			.cord_o  (cr_d[j+1]),
			.side_o  (cr_side[j+1])
		);
	end

	// round angles to unit scale and clamp
	always_comb begin
		el_a = cr_d[CRN].el.a < 0 ? '0 : cr_d[CRN].el.a;
		el_r = (AW'(el_a) + (AW'(1) << (29 - U))) >> (30 - U);
		el_c = el_r > AW'(psn_pkg::ONE) ? 15'(psn_pkg::ONE) : el_r[14:0];
		az_t = (AW+1)'(cr_d[CRN].az.a) + ((AW+1)'(1) <<< 31);
		if (az_t < 0)
			az_t = '0;
		else if (az_t > ((AW+1)'(1) <<< 32))
			az_t = (AW+1)'(1) <<< 32;
		az_r = ((AW+1)'(az_t) + ((AW+1)'(1) << (31 - U))) >> (32 - U);
		if (cr_d[CRN].az_zero)
			az_c = 15'(psn_pkg::ONE / 2);
		else if (az_r > (AW+1)'(psn_pkg::ONE))
			az_c = 15'(psn_pkg::ONE);
		else
			az_c = az_r[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cr_v[CRN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= cr_side[CRN];
			elevation_q <= el_c;
			azimuth_q <= az_c;
		end
	end

	assign out_valid         = out_valid_q;
	assign pressure_norm     = side_q.pressure;
	assign tilt_x_norm       = side_q.tx;
	assign tilt_y_norm       = side_q.ty;
	assign elevation         = elevation_q;
	assign azimuth           = azimuth_q;
	assign speed_norm        = side_q.speed;
	assign heading_fraction  = side_q.heading;
	assign rotation_fraction = side_q.rotation;
	assign rng_seed_out      = side_q.seed;
	assign stroke_rand_norm  = side_q.srand;

endmodule

### rtl/psn_checker.sv
// Port checker of the pen sample normalizer and its bind to the top level.
module psn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [14:0]        pressure_norm,
	input logic signed [15:0] tilt_x_norm,
	input logic [14:0]        elevation,
	input logic [14:0]        azimuth,
	input logic [31:0]        rng_seed_out
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// input stalls exactly while a result is held
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output hold");

	// a delivered seed is never zero
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rng_seed_out != 32'd0)
		else $error("zero seed delivered");

	// unit results stay within 0..1
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pressure_norm <= 15'(psn_pkg::ONE) &&
			elevation <= 15'(psn_pkg::ONE) && azimuth <= 15'(psn_pkg::ONE))
		else $error("unit result out of range");

	// no x tilt beyond one
	a_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tilt_x_norm <= 16'sd16384 && tilt_x_norm >= -16'sd16384)
		else $error("tilt not clamped");

endmodule

bind pen_sample_context_normalizer psn_checker u_psn_checker (.*);
